### rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared codes, field widths and parameter defaults for the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int DELAY_WIDTH_DEF = 16;

	localparam int REQ_W      = 2;
	localparam int ID_W       = 8;
	localparam int DELAY_IN_W = 16;
	localparam int STATUS_W   = 2;

	localparam logic [REQ_W-1:0] REQ_INSERT       = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE_CARRY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE_PLAIN = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

### rtl/delta_timer_queue_top.sv
// An insert runs alloc, a walk over the passed entries, then writes of the new entry,
// its successor and its predecessor as needed; a remove runs pop, an optional carry
// and the free-list write. Full, empty and unused requests go straight to finish. One
// request at a time; the walk reads one entry per cycle from the single-read-port RAM.
// Reset clears the control registers only; the entry RAM is not cleared. Never-used
// slots are tracked by a high-water counter instead, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// delta_timer_queue_top
// Sorted delta list of timer entries kept as linked slots in one entry RAM.
// ----------------------------------------------------------------------------
module delta_timer_queue_top #(
	parameter int CAPACITY    = dtq_pkg::CAPACITY_DEF,
	parameter int DELAY_WIDTH = dtq_pkg::DELAY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dtq_pkg::REQ_W-1:0]      req_type,
	input  logic [dtq_pkg::ID_W-1:0]       entry_id,
	input  logic [dtq_pkg::DELAY_IN_W-1:0] delay,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dtq_pkg::ID_W-1:0]       removed_id,
	output logic [dtq_pkg::STATUS_W-1:0]   status
);
	import dtq_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = DELAY_WIDTH;

	typedef struct packed {
		logic [IW-1:0]   link;
		logic [ID_W-1:0] id;
		logic [DW-1:0]   delta;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_WALK,
		S_WR_NODE,
		S_WR_CUR,
		S_WR_PREV,
		S_POP,
		S_CARRY,
		S_WR_OLD,
		S_FIN
	} state_t;

	state_t state_q;

	// Entry RAM, one write and one registered read per cycle.
	entry_t        mem [CAPACITY];
	entry_t        rd_q;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;

	// Control state.
	logic [IW-1:0] head_q;
	logic [IW-1:0] free_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] hw_q;
	logic          out_valid_q;
	logic [ID_W-1:0]     removed_id_q;
	logic [STATUS_W-1:0] status_q;

	// Per-request working registers.
	logic [DW-1:0]       delay_q;
	logic [ID_W-1:0]     id_q;
	logic [IW-1:0]       node_q;
	logic [IW-1:0]       cur_q;
	logic [IW-1:0]       prev_q;
	logic [IW-1:0]       old_q;
	logic [IW-1:0]       next_q;
	logic [CW-1:0]       passed_q;
	logic                has_prev_q;
	logic                stop_q;
	logic                carry_q;
	entry_t              cur_word_q;
	entry_t              prev_word_q;
	entry_t              old_word_q;
	logic [ID_W-1:0]     res_id_q;
	logic [STATUS_W-1:0] res_status_q;

	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic [31:0]   delay_ext;
	logic [DW-1:0] delay_in;
	logic          walk_go;
	logic [DW:0]   carry_sum;
	logic [DW-1:0] carry_sat;
	logic [IW-1:0] node_succ;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign is_full   = (count_q == CW'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign delay_ext = 32'(delay);
	assign delay_in  = delay_ext[DW-1:0];

	// The walk passes an entry while its delta still fits into the remaining delay,
	// so a new entry lands after every entry with an equal absolute delay.
	assign walk_go   = (passed_q != count_q) && (delay_q >= rd_q.delta);

	assign carry_sum = {1'b0, rd_q.delta} + {1'b0, old_word_q.delta};
	assign carry_sat = carry_sum[DW] ? {DW{1'b1}} : carry_sum[DW-1:0];

	// Successor of a never-used slot in the initial free chain.
	assign node_succ = (node_q == IW'(CAPACITY - 1)) ? '0 : node_q + 1'b1;

	always_comb begin
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = cur_word_q;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = (req_type == REQ_INSERT) ? free_q : head_q;
			end
			S_ALLOC: begin
				rd_addr = cur_q;
			end
			S_WALK: begin
				rd_addr = rd_q.link;
			end
			S_POP: begin
				rd_addr = rd_q.link;
			end
			S_WR_NODE: begin
				wr_en         = 1'b1;
				wr_addr       = node_q;
				wr_data.link  = stop_q ? cur_q : '0;
				wr_data.id    = id_q;
				wr_data.delta = delay_q;
			end
			S_WR_CUR: begin
				wr_en         = 1'b1;
				wr_addr       = cur_q;
				wr_data       = cur_word_q;
				wr_data.delta = cur_word_q.delta - delay_q;
			end
			S_WR_PREV: begin
				wr_en        = 1'b1;
				wr_addr      = prev_q;
				wr_data      = prev_word_q;
				wr_data.link = node_q;
			end
			S_CARRY: begin
				wr_en         = 1'b1;
				wr_addr       = next_q;
				wr_data       = rd_q;
				wr_data.delta = carry_sat;
			end
			S_WR_OLD: begin
				wr_en        = 1'b1;
				wr_addr      = old_q;
				wr_data      = old_word_q;
				wr_data.link = free_q;
			end
			S_FIN: begin
				rd_addr = cur_q;
			end
			default: begin
				rd_addr = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Working registers; they carry no control meaning across requests.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				delay_q    <= delay_in;
				id_q       <= entry_id;
				node_q     <= free_q;
				cur_q      <= head_q;
				old_q      <= head_q;
				passed_q   <= '0;
				has_prev_q <= 1'b0;
				carry_q    <= (req_type == REQ_REMOVE_CARRY);
				res_id_q   <= '0;
				if (req_type == REQ_INSERT && is_full) begin
					res_status_q <= STATUS_FULL;
				end else if ((req_type == REQ_REMOVE_CARRY ||
						req_type == REQ_REMOVE_PLAIN) && is_empty) begin
					res_status_q <= STATUS_EMPTY;
				end else begin
					res_status_q <= STATUS_OK;
				end
			end
			S_WALK: begin
				if (walk_go) begin
					delay_q     <= delay_q - rd_q.delta;
					prev_q      <= cur_q;
					prev_word_q <= rd_q;
					has_prev_q  <= 1'b1;
					cur_q       <= rd_q.link;
					passed_q    <= passed_q + 1'b1;
				end else begin
					stop_q     <= (passed_q != count_q);
					cur_word_q <= rd_q;
				end
			end
			S_POP: begin
				res_id_q   <= rd_q.id;
				old_word_q <= rd_q;
				next_q     <= rd_q.link;
			end
			default: begin
				res_id_q <= res_id_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			free_q       <= '0;
			count_q      <= '0;
			hw_q         <= '0;
			out_valid_q  <= 1'b0;
			removed_id_q <= '0;
			status_q     <= STATUS_OK;
		end else begin
			// The finish state owns the result beat while it waits there.
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_INSERT) begin
							state_q <= is_full ? S_FIN : S_ALLOC;
						end else if (req_type == REQ_REMOVE_CARRY ||
								req_type == REQ_REMOVE_PLAIN) begin
							state_q <= is_empty ? S_FIN : S_POP;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_ALLOC: begin
					// A slot at the high-water mark was never written; its link
					// is the next slot of the initial chain.
					if (CW'(node_q) == hw_q) begin
						free_q <= node_succ;
						hw_q   <= hw_q + 1'b1;
					end else begin
						free_q <= rd_q.link;
					end
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (!walk_go) begin
						state_q <= S_WR_NODE;
					end
				end
				S_WR_NODE: begin
					count_q <= count_q + 1'b1;
					if (!has_prev_q) begin
						head_q <= node_q;
					end
					if (stop_q) begin
						state_q <= S_WR_CUR;
					end else if (has_prev_q) begin
						state_q <= S_WR_PREV;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_WR_CUR: begin
					state_q <= has_prev_q ? S_WR_PREV : S_FIN;
				end
				S_WR_PREV: begin
					state_q <= S_FIN;
				end
				S_POP: begin
					count_q <= count_q - 1'b1;
					head_q  <= (count_q != CW'(1)) ? rd_q.link : '0;
					if (carry_q && count_q != CW'(1)) begin
						state_q <= S_CARRY;
					end else begin
						state_q <= S_WR_OLD;
					end
				end
				S_CARRY: begin
					state_q <= S_WR_OLD;
				end
				S_WR_OLD: begin
					free_q  <= old_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						removed_id_q <= res_id_q;
						status_q     <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign removed_id = removed_id_q;
	assign status     = status_q;

`ifndef SYNTH
	// Live entries can never outnumber the slots, nor the slots ever handed out.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CW'(CAPACITY)) && (count_q <= hw_q))
		else $error("entry count exceeds capacity or used slots");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (passed_q <= count_q))
		else $error("insert walk passed more entries than are live");

	// The slot being filled came from the free list and cannot be the successor.
	a_node_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR_NODE && stop_q) |-> (node_q != cur_q))
		else $error("new entry links to itself");

	a_prev_link: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR_PREV) |-> (has_prev_q && prev_q != node_q))
		else $error("predecessor link written without a predecessor");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result beat raised outside the finish state");
`endif

endmodule

### bench/delta_timer_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_timer_queue_checker
// Watches both channels of the delta timer queue. Each accepted request runs
// through a software copy of the sorted delta list. Each accepted result is
// compared field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module delta_timer_queue_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [dtq_pkg::REQ_W-1:0]      req_type,
	input  logic [dtq_pkg::ID_W-1:0]       entry_id,
	input  logic [dtq_pkg::DELAY_IN_W-1:0] delay,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [dtq_pkg::ID_W-1:0]       removed_id,
	input  logic [dtq_pkg::STATUS_W-1:0]   status,
	output int                             mismatches,
	output int                             pending
);
	import dtq_pkg::*;

	localparam int SLOTS  = CAPACITY_DEF;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int LIVE_W = $clog2(SLOTS) + 1;

	typedef logic [DELAY_WIDTH_DEF-1:0] tick_t;
	typedef logic [IDX_W-1:0]           slot_t;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [STATUS_W-1:0] status;
	} timer_result_t;

	tick_t           delta_mem [SLOTS];
	logic [ID_W-1:0] tag_mem [SLOTS];
	slot_t           next_mem [SLOTS];
	slot_t           head_slot;
	slot_t           free_slot;
	logic [LIVE_W-1:0] live;

	timer_result_t expected_results [$];

	function automatic timer_result_t apply_request(input logic [REQ_W-1:0] req,
			input logic [ID_W-1:0] id, input logic [DELAY_IN_W-1:0] dly);
		timer_result_t  res;
		slot_t          node, cur, prev, nxt;
		tick_t          rem;
		int             passed;
		bit             has_prev;
		logic [DELAY_WIDTH_DEF:0] sum;

		res.id     = '0;
		res.status = STATUS_OK;
		case (req)
			REQ_INSERT: begin
				if (live >= LIVE_W'(SLOTS)) begin
					res.status = STATUS_FULL;
					return res;
				end
				node          = free_slot;
				free_slot     = next_mem[node];
				tag_mem[node] = id;
				// Walk past every entry whose absolute delay does not exceed ours.
				cur      = head_slot;
				prev     = '0;
				has_prev = 1'b0;
				passed   = 0;
				rem      = tick_t'(dly);
				while (passed < int'(live) && rem >= delta_mem[cur]) begin
					rem      = rem - delta_mem[cur];
					prev     = cur;
					has_prev = 1'b1;
					cur      = next_mem[cur];
					passed++;
				end
				delta_mem[node] = rem;
				if (passed < int'(live)) begin
					delta_mem[cur] = delta_mem[cur] - rem;
					next_mem[node] = cur;
				end else begin
					next_mem[node] = '0;
				end
				if (has_prev) begin
					next_mem[prev] = node;
				end else begin
					head_slot = node;
				end
				live++;
			end
			REQ_REMOVE_CARRY, REQ_REMOVE_PLAIN: begin
				if (live == '0) begin
					res.status = STATUS_EMPTY;
					return res;
				end
				node   = head_slot;
				res.id = tag_mem[node];
				nxt    = next_mem[node];
				live--;
				if (req == REQ_REMOVE_CARRY && live != '0) begin
					sum = {1'b0, delta_mem[nxt]} + {1'b0, delta_mem[node]};
					delta_mem[nxt] = sum[DELAY_WIDTH_DEF] ? '1 : sum[DELAY_WIDTH_DEF-1:0];
				end
				head_slot      = (live != '0) ? nxt : '0;
				next_mem[node] = free_slot;
				free_slot      = node;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		int            errs;

		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				delta_mem[i] = '0;
				tag_mem[i]   = '0;
				next_mem[i]  = slot_t'(i + 1);
			end
			head_slot = '0;
			free_slot = '0;
			live      = '0;
			expected_results.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			errs = 0;
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_request(req_type, entry_id, delay));
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected, removed_id %0d status %0d",
						$time, removed_id, status);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (removed_id !== want.id) begin
						$display("%0t: removed_id expected %0d, actual %0d",
							$time, want.id, removed_id);
						errs++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, status);
						errs++;
					end
				end
			end
			mismatches <= mismatches + errs;
			pending    <= expected_results.size();
		end
	end

endmodule

### bench/delta_timer_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_timer_queue_top_tb
// Drives timer requests into the delta timer queue: a directed opening over
// empty removes, boundary delays and equal-delay ordering, then random phases
// that fill, drain and overfill the list under random idles and back-pressure.
// ----------------------------------------------------------------------------
module delta_timer_queue_top_tb;
	import dtq_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 1050;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef enum int {
		PHASE_MIXED,
		PHASE_FILL,
		PHASE_DRAIN,
		PHASE_TO_FULL
	} phase_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [REQ_W-1:0]      req_type   = '0;
	logic [ID_W-1:0]       entry_id   = '0;
	logic [DELAY_IN_W-1:0] delay      = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [ID_W-1:0]       removed_id;
	logic [STATUS_W-1:0]   status;

	int                    mismatches;
	int                    pending;
	int                    cycle_count = 0;
	int                    stall_left  = 0;
	bit                    stalls_on   = 1'b1;
	bit                    gaps_on     = 1'b1;
	logic [DELAY_IN_W-1:0] last_delay  = '0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	delta_timer_queue_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.entry_id   (entry_id),
		.delay      (delay),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.removed_id (removed_id),
		.status     (status)
	);

	delta_timer_queue_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.entry_id   (entry_id),
		.delay      (delay),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.removed_id (removed_id),
		.status     (status),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Back-pressure comes in bursts: mostly short, now and then a long hold.
	always @(posedge clk) begin
		int r;

		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!stalls_on) begin
			out_stall  <= 1'b0;
			stall_left <= $urandom_range(4, 30);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_stall  <= 1'b0;
				stall_left <= $urandom_range(0, 4);
			end else if (r < 92) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(20, 60);
			end
		end
	end

	function automatic int pick_gap();
		int r;

		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	function automatic logic [DELAY_IN_W-1:0] pick_delay();
		int r;

		r = $urandom_range(0, 99);
		if (r < 25) return DELAY_IN_W'($urandom_range(0, 7));
		if (r < 30) return '0;
		if (r < 35) return '1;
		// Reusing a recent delay makes ties with live entries common.
		if (r < 50) return last_delay;
		return DELAY_IN_W'($urandom_range(0, 65535));
	endfunction

	// Presents one request and returns at the edge where it is accepted.
	task automatic send_req(input logic [REQ_W-1:0] rq, input logic [ID_W-1:0] id,
			input logic [DELAY_IN_W-1:0] dly);
		int gap;

		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		entry_id <= id;
		delay    <= dly;
		if (rq == REQ_INSERT) last_delay = dly;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic run_phase(input phase_t kind, input int count);
		int insert_pct;
		int noise_pct;
		int r;

		case (kind)
			PHASE_FILL:    begin insert_pct = 88;  noise_pct = 3; end
			PHASE_DRAIN:   begin insert_pct = 15;  noise_pct = 3; end
			PHASE_TO_FULL: begin insert_pct = 100; noise_pct = 0; end
			default:       begin insert_pct = 52;  noise_pct = 4; end
		endcase
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < noise_pct) begin
				send_req(REQ_UNUSED, ID_W'($urandom), DELAY_IN_W'($urandom));
			end else if (r < noise_pct + insert_pct) begin
				send_req(REQ_INSERT, ID_W'($urandom_range(0, 255)), pick_delay());
			end else if ($urandom_range(0, 1) == 0) begin
				send_req(REQ_REMOVE_CARRY, ID_W'($urandom), DELAY_IN_W'($urandom));
			end else begin
				send_req(REQ_REMOVE_PLAIN, ID_W'($urandom), DELAY_IN_W'($urandom));
			end
		end
	endtask

	initial begin
		phase_t kind;
		int     len;
		int     sent;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: empty removes, an unused request code, boundary
		// delays, ties placed behind existing entries and a successor adjusted
		// by a mid-list insert, then a full drain with both remove kinds.
		send_req(REQ_REMOVE_CARRY, 8'hff, 16'hffff);
		send_req(REQ_REMOVE_PLAIN, 8'h00, 16'h0000);
		send_req(REQ_UNUSED,       8'hff, 16'hffff);
		send_req(REQ_INSERT,       8'h00, 16'h0000);
		send_req(REQ_INSERT,       8'hff, 16'hffff);
		send_req(REQ_INSERT,       8'h55, 16'd100);
		send_req(REQ_INSERT,       8'haa, 16'd100);
		send_req(REQ_INSERT,       8'h11, 16'h0000);
		send_req(REQ_INSERT,       8'h22, 16'd50);
		send_req(REQ_INSERT,       8'h33, 16'hffff);
		send_req(REQ_REMOVE_CARRY, 8'h00, 16'h0000);
		send_req(REQ_REMOVE_PLAIN, 8'h00, 16'h0000);
		send_req(REQ_REMOVE_CARRY, 8'h00, 16'h0000);
		send_req(REQ_INSERT,       8'h44, 16'd60);
		send_req(REQ_REMOVE_PLAIN, 8'h00, 16'h0000);
		send_req(REQ_REMOVE_CARRY, 8'h00, 16'h0000);
		send_req(REQ_REMOVE_CARRY, 8'h00, 16'h0000);
		send_req(REQ_REMOVE_PLAIN, 8'h00, 16'h0000);
		send_req(REQ_REMOVE_CARRY, 8'h00, 16'h0000);
		send_req(REQ_REMOVE_PLAIN, 8'h00, 16'h0000);

		sent = 0;
		kind = PHASE_TO_FULL;
		while (sent < RANDOM_ITEMS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on <= ($urandom_range(0, 3) != 0);
			// A to-full phase sends seventy inserts, more than the capacity, unless the last phase is cut to the items left.
			len = (kind == PHASE_TO_FULL) ? 70 : $urandom_range(40, 120);
			if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
			run_phase(kind, len);
			sent += len;
			kind = phase_t'($urandom_range(0, 3));
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
